// ===== rtl/core/hsu_pkg.sv =====
`default_nettype none
package hsu_pkg;

	localparam int KEY_W = 31;

	localparam logic [2:0] MODE_INS_A   = 3'd0;
	localparam logic [2:0] MODE_INS_B   = 3'd1;
	localparam logic [2:0] MODE_DEL_A   = 3'd2;
	localparam logic [2:0] MODE_DEL_B   = 3'd3;
	localparam logic [2:0] MODE_QRY_A   = 3'd4;
	localparam logic [2:0] MODE_QRY_B   = 3'd5;
	localparam logic [2:0] MODE_INTER   = 3'd6;
	localparam logic [2:0] MODE_UNION   = 3'd7;

	localparam logic [2:0] ST_DONE      = 3'd0;
	localparam logic [2:0] ST_DUP       = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_BKT_FULL  = 3'd3;
	localparam logic [2:0] ST_SET_FULL  = 3'd4;
	localparam logic [2:0] ST_EMIT      = 3'd5;

	typedef struct packed {
		logic [2:0]       mode;
		logic [KEY_W-1:0] key_value;
	} cmd_t;

	typedef struct packed {
		logic [KEY_W-1:0] result_key;
		logic [2:0]       status;
		logic             present;
		logic             has_key;
		logic             last;
	} res_t;

endpackage
`default_nettype wire

// ===== rtl/core/hash_set_union_intersection.sv =====
`default_nettype none
// Two hashed key sets, A and B, each with BUCKETS buckets (bucket = key mod BUCKETS) holding
// chains of up to CHAIN_DEPTH keys in insertion order, at most SET_CAPACITY keys per set.
// A command beat is taken when start is high and busy is low; busy then stays high until the
// last result beat has gone out. Results appear for one cycle each, flagged by valid, and the
// receiver cannot stall them; the final beat of a command carries last. Insert, delete and
// query give one beat; intersect and union give one beat per element, or a single empty beat.
// The bucket index comes from a reciprocal multiply and one correcting subtract; insert,
// delete and query then compare the chain slot by slot in the key store (registered read),
// and a delete moves each later slot up to close the gap. Intersect and union walk every
// bucket and each key of the source set, searching the other set for the key where the mode
// filters it; union walks both sets. Each result beat shows on the ports the cycle after it
// is made.
// Key stores come up undefined but only slots below a bucket's fill count are ever used, and
// the fill counts clear at reset, so no clearing pass is needed.
module hash_set_union_intersection
	import hsu_pkg::*;
#(
	parameter int BUCKETS      = 23,
	parameter int CHAIN_DEPTH  = 4,
	parameter int SET_CAPACITY = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire cmd_t command,
	output logic      busy,
	output logic      valid,
	output res_t      result
);

	localparam int BW    = $clog2(BUCKETS);
	localparam int SLOTS = BUCKETS * CHAIN_DEPTH;
	localparam int AW    = $clog2(SLOTS);
	localparam int FW    = $clog2(CHAIN_DEPTH + 1);
	localparam int TW    = $clog2(SET_CAPACITY + 1);

	// floor(2^KEY_W / BUCKETS): the quotient estimate is at most one short
	localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / BUCKETS);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MOD  = 4'd1;
	localparam logic [3:0] S_FRD  = 4'd2;
	localparam logic [3:0] S_FCMP = 4'd3;
	localparam logic [3:0] S_ACT  = 4'd4;
	localparam logic [3:0] S_SHRD = 4'd5;
	localparam logic [3:0] S_SHWR = 4'd6;
	localparam logic [3:0] S_ERD  = 4'd7;
	localparam logic [3:0] S_EKEY = 4'd8;
	localparam logic [3:0] S_EDEC = 4'd9;
	localparam logic [3:0] S_EMIT = 4'd10;
	localparam logic [3:0] S_EFIN = 4'd11;
	localparam logic [3:0] S_MUL  = 4'd12;

	logic [3:0]         state_q;
	logic [2:0]         mode_q;
	logic [KEY_W-1:0]   key_q;
	logic [KEY_W-1:0]   pend_key_q;
	logic               pend_q;
	logic               sel_q;     // set searched: 0 A, 1 B; emission source is the other
	logic               phase_q;   // emission: 0 walking B, 1 walking A
	logic               found_q;
	logic [BW-1:0]      bkt_q;
	logic [2*KEY_W-1:0] prod_q;
	logic [FW-1:0]      idx_q;
	logic [FW-1:0]      sidx_q;
	logic [FW-1:0]      fill_a_q [BUCKETS];
	logic [FW-1:0]      fill_b_q [BUCKETS];
	logic [TW-1:0]      total_a_q;
	logic [TW-1:0]      total_b_q;
	logic               valid_q;
	res_t               result_q;

	logic [KEY_W-1:0] rdata_a, rdata_b, rdata_sel, rdata_src;
	logic [AW-1:0]    base, rd_addr, wr_addr;
	logic [KEY_W-1:0] wr_data;
	logic             wr_en;
	logic [FW-1:0]    fill_sel, fill_src;
	logic [TW-1:0]    total_sel;
	logic [KEY_W-1:0] quot_est;
	logic [BW:0]      rem_est;
	logic [BW-1:0]    rem_next;
	logic             emitting, filtered, key_match;

	assign busy   = (state_q != S_IDLE);
	assign valid  = valid_q;
	assign result = result_q;

	assign fill_sel  = sel_q ? fill_b_q[bkt_q] : fill_a_q[bkt_q];
	assign fill_src  = sel_q ? fill_a_q[bkt_q] : fill_b_q[bkt_q];
	assign total_sel = sel_q ? total_b_q : total_a_q;
	assign rdata_sel = sel_q ? rdata_b : rdata_a;
	assign rdata_src = sel_q ? rdata_a : rdata_b;
	assign key_match = (rdata_sel == key_q);   // the one shared comparator

	assign emitting = (mode_q == MODE_INTER) || (mode_q == MODE_UNION);
	assign filtered = phase_q || (mode_q == MODE_INTER);

	// remainder from the quotient estimate lies below 2*BUCKETS: one subtract corrects it
	assign quot_est = prod_q[2*KEY_W-1:KEY_W];
	assign rem_est  = (BW+1)'(key_q) - (BW+1)'(quot_est) * (BW+1)'(BUCKETS);
	assign rem_next = (rem_est >= (BW+1)'(BUCKETS)) ?
		BW'(rem_est - (BW+1)'(BUCKETS)) : BW'(rem_est);

	assign base = AW'(bkt_q) * AW'(CHAIN_DEPTH);

	always_comb begin
		case (state_q)
			S_FRD:   rd_addr = base + AW'(idx_q);
			S_SHRD:  rd_addr = base + AW'(idx_q) + AW'(1);
			S_ERD:   rd_addr = base + AW'(sidx_q);
			default: rd_addr = base;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = base + AW'(idx_q);
		wr_data = rdata_sel;
		case (state_q)
			S_ACT: begin
				if ((mode_q == MODE_INS_A || mode_q == MODE_INS_B) && !found_q &&
				    fill_sel < FW'(CHAIN_DEPTH) && total_sel < TW'(SET_CAPACITY)) begin
					wr_en   = 1'b1;
					wr_addr = base + AW'(fill_sel);
					wr_data = key_q;
				end
			end
			S_SHWR:  wr_en = 1'b1;
			default: wr_en = 1'b0;
		endcase
	end

	hsu_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_ram_a (
		.clk   (clk),
		.we    (wr_en && !sel_q),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rdata_a)
	);

	hsu_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_ram_b (
		.clk   (clk),
		.we    (wr_en && sel_q),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= 1'b0;
			pend_q    <= 1'b0;
			total_a_q <= '0;
			total_b_q <= '0;
			for (int i = 0; i < BUCKETS; i++) begin
				fill_a_q[i] <= '0;
				fill_b_q[i] <= '0;
			end
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						mode_q <= command.mode;
						key_q  <= command.key_value;
						if (command.mode == MODE_INTER || command.mode == MODE_UNION) begin
							sel_q   <= 1'b0;
							phase_q <= 1'b0;
							bkt_q   <= '0;
							sidx_q  <= '0;
							pend_q  <= 1'b0;
							state_q <= S_ERD;
						end else begin
							sel_q   <= command.mode[0];
							state_q <= S_MUL;
						end
					end
				end
				// multiply by the reciprocal, then correct the remainder
				S_MUL: begin
					prod_q  <= (2*KEY_W)'(key_q) * (2*KEY_W)'(RECIP);
					state_q <= S_MOD;
				end
				S_MOD: begin
					bkt_q   <= rem_next;
					idx_q   <= '0;
					state_q <= S_FRD;
				end
				// chain search of set sel_q, bucket bkt_q, for key_q
				S_FRD: begin
					if (idx_q == fill_sel) begin
						found_q <= 1'b0;
						state_q <= emitting ? S_EDEC : S_ACT;
					end else begin
						state_q <= S_FCMP;
					end
				end
				S_FCMP: begin
					if (key_match) begin
						found_q <= 1'b1;
						state_q <= emitting ? S_EDEC : S_ACT;
					end else begin
						idx_q   <= idx_q + FW'(1);
						state_q <= S_FRD;
					end
				end
				S_ACT: begin
					result_q.result_key <= key_q;
					result_q.present    <= 1'b0;
					result_q.has_key    <= 1'b0;
					result_q.last       <= 1'b1;
					result_q.status     <= ST_DONE;
					state_q             <= S_IDLE;
					case (mode_q)
						MODE_INS_A, MODE_INS_B: begin
							valid_q <= 1'b1;
							if (found_q) begin
								result_q.status <= ST_DUP;
							end else if (fill_sel >= FW'(CHAIN_DEPTH)) begin
								result_q.status <= ST_BKT_FULL;
							end else if (total_sel >= TW'(SET_CAPACITY)) begin
								result_q.status <= ST_SET_FULL;
							end else if (sel_q) begin
								fill_b_q[bkt_q] <= fill_b_q[bkt_q] + FW'(1);
								total_b_q       <= total_b_q + TW'(1);
							end else begin
								fill_a_q[bkt_q] <= fill_a_q[bkt_q] + FW'(1);
								total_a_q       <= total_a_q + TW'(1);
							end
						end
						MODE_DEL_A, MODE_DEL_B: begin
							if (found_q) begin
								state_q <= S_SHRD;
							end else begin
								valid_q         <= 1'b1;
								result_q.status <= ST_NOT_FOUND;
							end
						end
						default: begin
							valid_q          <= 1'b1;
							result_q.present <= found_q;
						end
					endcase
				end
				// close the gap: move each later slot up by one
				S_SHRD: begin
					if (idx_q + FW'(1) >= fill_sel) begin
						if (sel_q) begin
							fill_b_q[bkt_q] <= fill_b_q[bkt_q] - FW'(1);
							total_b_q       <= total_b_q - TW'(1);
						end else begin
							fill_a_q[bkt_q] <= fill_a_q[bkt_q] - FW'(1);
							total_a_q       <= total_a_q - TW'(1);
						end
						valid_q  <= 1'b1;
						result_q <= '{result_key: key_q, status: ST_DONE, present: 1'b0,
						              has_key: 1'b0, last: 1'b1};
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_SHWR;
					end
				end
				S_SHWR: begin
					idx_q   <= idx_q + FW'(1);
					state_q <= S_SHRD;
				end
				// emission walk over the source set
				S_ERD: begin
					if (sidx_q == fill_src) begin
						sidx_q <= '0;
						if (bkt_q == BW'(BUCKETS - 1)) begin
							bkt_q <= '0;
							if (!phase_q && mode_q == MODE_UNION) begin
								phase_q <= 1'b1;
								sel_q   <= 1'b1;
							end else begin
								state_q <= S_EFIN;
							end
						end else begin
							bkt_q <= bkt_q + BW'(1);
						end
					end else begin
						state_q <= S_EKEY;
					end
				end
				S_EKEY: begin
					key_q <= rdata_src;
					idx_q <= '0;
					state_q <= filtered ? S_FRD : S_EMIT;
				end
				S_EDEC: begin
					if (found_q == !phase_q) begin
						state_q <= S_EMIT;
					end else begin
						sidx_q  <= sidx_q + FW'(1);
						state_q <= S_ERD;
					end
				end
				S_EMIT: begin
					// hold one element back so the final beat can carry last
					if (pend_q) begin
						valid_q  <= 1'b1;
						result_q <= '{result_key: pend_key_q, status: ST_EMIT, present: 1'b0,
						              has_key: 1'b1, last: 1'b0};
					end
					pend_key_q <= key_q;
					pend_q     <= 1'b1;
					sidx_q     <= sidx_q + FW'(1);
					state_q    <= S_ERD;
				end
				S_EFIN: begin
					valid_q <= 1'b1;
					if (pend_q) begin
						result_q <= '{result_key: pend_key_q, status: ST_EMIT, present: 1'b0,
						              has_key: 1'b1, last: 1'b1};
					end else begin
						result_q <= '{result_key: '0, status: ST_DONE, present: 1'b0,
						              has_key: 1'b0, last: 1'b1};
					end
					pend_q  <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/hsu_ram.sv =====
`default_nettype none
module hsu_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 92,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/core/hsu_checker.sv =====
`default_nettype none
module hsu_checker
	import hsu_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire cmd_t command,
	input wire logic busy,
	input wire logic valid,
	input wire res_t result
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("command beat taken but block not busy");

	a_more_after: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !result.last |=> busy)
		else $error("block idle after a non-final result beat");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> valid && result.last)
		else $error("block went idle without a final result beat");

	a_key_status: assert property (@(posedge clk) disable iff (!arst_n)
		valid && result.has_key |-> result.status == ST_EMIT && !result.present)
		else $error("emitted element with wrong status");

	a_present: assert property (@(posedge clk) disable iff (!arst_n)
		valid && result.present |-> result.status == ST_DONE && result.last)
		else $error("query answer on an unexpected beat");

endmodule

bind hash_set_union_intersection hsu_checker u_hsu_checker (.*);
`default_nettype wire

// ===== tb/sv/hash_set_checker.sv =====
module hash_set_checker
	import hsu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic busy,
	input  wire cmd_t command,
	input  wire logic valid,
	input  wire res_t result,
	output int        fail_count,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NB = 23;
	localparam int DEPTH = 4;
	localparam int CAP = 32;

	typedef struct {
		logic [KEY_W-1:0] slot [NB][DEPTH];
		int               fill [NB];
		int               total;
	} shadow_set_t;

	shadow_set_t set_a, set_b;
	res_t        expected_beats [$];

	function automatic int locate(ref shadow_set_t s, input logic [KEY_W-1:0] key);
		int b;
		b = int'(key % NB);
		for (int i = 0; i < s.fill[b]; i++)
			if (s.slot[b][i] == key)
				return i;
		return -1;
	endfunction

	function automatic logic [2:0] add_key(ref shadow_set_t s, input logic [KEY_W-1:0] key);
		int b;
		b = int'(key % NB);
		if (locate(s, key) >= 0)
			return ST_DUP;
		if (s.fill[b] >= DEPTH)
			return ST_BKT_FULL;
		if (s.total >= CAP)
			return ST_SET_FULL;
		s.slot[b][s.fill[b]] = key;
		s.fill[b]++;
		s.total++;
		return ST_DONE;
	endfunction

	function automatic logic [2:0] drop_key(ref shadow_set_t s, input logic [KEY_W-1:0] key);
		int b, pos;
		b = int'(key % NB);
		pos = locate(s, key);
		if (pos < 0)
			return ST_NOT_FOUND;
		for (int i = pos; i + 1 < s.fill[b]; i++)
			s.slot[b][i] = s.slot[b][i+1];
		s.fill[b]--;
		s.total--;
		return ST_DONE;
	endfunction

	function automatic void push_beat(logic [KEY_W-1:0] key, logic [2:0] st, logic pres,
			logic hk);
		res_t r;
		r.result_key = key;
		r.status = st;
		r.present = pres;
		r.has_key = hk;
		r.last = 1'b0;
		expected_beats.push_back(r);
	endfunction

	// emit every key of src in bucket/chain order, optionally filtered on other
	function automatic void walk_emit(ref shadow_set_t src, ref shadow_set_t other,
			input bit filtered, input bit want_in);
		for (int b = 0; b < NB; b++)
			for (int i = 0; i < src.fill[b]; i++)
				if (!filtered || ((locate(other, src.slot[b][i]) >= 0) == want_in))
					push_beat(src.slot[b][i], ST_EMIT, 1'b0, 1'b1);
	endfunction

	function automatic void predict_command(cmd_t c);
		int prior_size;
		prior_size = expected_beats.size();
		case (c.mode)
			MODE_INS_A: push_beat(c.key_value, add_key(set_a, c.key_value), 1'b0, 1'b0);
			MODE_INS_B: push_beat(c.key_value, add_key(set_b, c.key_value), 1'b0, 1'b0);
			MODE_DEL_A: push_beat(c.key_value, drop_key(set_a, c.key_value), 1'b0, 1'b0);
			MODE_DEL_B: push_beat(c.key_value, drop_key(set_b, c.key_value), 1'b0, 1'b0);
			MODE_QRY_A: push_beat(c.key_value, ST_DONE, locate(set_a, c.key_value) >= 0,
				1'b0);
			MODE_QRY_B: push_beat(c.key_value, ST_DONE, locate(set_b, c.key_value) >= 0,
				1'b0);
			MODE_INTER: walk_emit(set_b, set_a, 1'b1, 1'b1);
			default: begin
				walk_emit(set_b, set_a, 1'b0, 1'b1);
				walk_emit(set_a, set_b, 1'b1, 1'b0);
			end
		endcase
		if (expected_beats.size() == prior_size)
			push_beat('0, ST_DONE, 1'b0, 1'b0);
		expected_beats[$].last = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			for (int b = 0; b < NB; b++) begin
				set_a.fill[b] = 0;
				set_b.fill[b] = 0;
			end
			set_a.total = 0;
			set_b.total = 0;
			expected_beats.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (valid) begin
				if (expected_beats.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result beat %p", result);
				end else begin
					want = expected_beats.pop_front();
					if (result !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %p, got %p", want, result);
					end
				end
			end
			if (start && !busy)
				predict_command(command);
			pending = expected_beats.size();
		end
	end
endmodule

// ===== tb/sv/hash_set_union_intersection_test.sv =====
module hash_set_union_intersection_test;
	import hsu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t command = '0;
	logic busy, valid;
	res_t result;
	int   fail_count, pending;
	int   quiet_cycles = 0;

	hash_set_union_intersection dut (
		.clk(clk), .arst_n(arst_n), .start(start), .command(command),
		.busy(busy), .valid(valid), .result(result)
	);

	hash_set_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .command(command),
		.valid(valid), .result(result), .fail_count(fail_count), .pending(pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog: count cycles in which no beat moves either way
	always @(posedge clk) begin
		if ((start && !busy) || valid)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// hold the beat until the block takes it, then drop start on the falling edge
	// and keep it low for one cycle
	task automatic send(logic [2:0] m, logic [KEY_W-1:0] k);
		command <= '{mode: m, key_value: k};
		start <= 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
		start <= 1'b0;
		@(negedge clk);
	endtask

	task automatic pause();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0)
			n = 0;
		repeat (n) @(negedge clk);
	endtask

	// keys in a small pool collide in buckets and repeat often
	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 5))
			0: return KEY_W'($urandom & 32'h7FFF_FFFF);
			1: return KEY_W'(23 * $urandom_range(0, 6) + $urandom_range(0, 2));
			default: return KEY_W'($urandom_range(0, 80));
		endcase
	endfunction

	initial begin
		logic [2:0] m;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty emissions, delete from an empty bucket, query of an empty set
		send(MODE_INTER, 31'd5);
		send(MODE_UNION, 31'h7FFF_FFFF);
		send(MODE_DEL_A, 31'd7);
		send(MODE_QRY_B, 31'd7);
		// extremes of the key and a duplicate
		send(MODE_INS_A, 31'h7FFF_FFFF);
		send(MODE_INS_A, 31'd0);
		send(MODE_INS_A, 31'd0);
		send(MODE_INS_B, 31'h7FFF_FFFF);
		send(MODE_INS_B, 31'h2AAA_AAAA);
		// fill bucket 0 of B and overflow it
		for (int i = 1; i <= 5; i++)
			send(MODE_INS_B, 31'(23 * i));
		// delete mid-chain to close the gap
		send(MODE_DEL_B, 31'd46);
		send(MODE_QRY_A, 31'd0);
		send(MODE_QRY_B, 31'd46);
		send(MODE_INTER, 31'd0);
		send(MODE_UNION, 31'd0);
		send(MODE_DEL_B, 31'd46);
		// fill A up to capacity, one key per bucket then more, to hit set full
		for (int i = 1; i <= 34; i++)
			send(MODE_INS_A, 31'(i * 101));
		send(MODE_UNION, 31'd0);
		send(MODE_INTER, 31'd0);

		for (int n = 0; n < 75; n++) begin
			case ($urandom_range(0, 15))
				0, 1, 2, 3: m = MODE_INS_A;
				4, 5, 6, 7: m = MODE_INS_B;
				8, 9: m = MODE_DEL_A;
				10, 11: m = MODE_DEL_B;
				12: m = MODE_QRY_A;
				13: m = MODE_QRY_B;
				14: m = MODE_INTER;
				default: m = MODE_UNION;
			endcase
			send(m, pick_key());
			pause();
		end

		while (pending != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/core/hsu_pkg.sv
rtl/core/hsu_ram.sv
rtl/core/hash_set_union_intersection.sv
rtl/core/hsu_checker.sv
tb/sv/hash_set_checker.sv
tb/sv/hash_set_union_intersection_test.sv
